FILE: hw/rtl/skpq_pkg.sv
package skpq_pkg;

  // Operation codes carried on the input tuser field.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_TEST   = 2'd3;

  // Fixed field widths of the stream items.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned IN_W     = 32;
  localparam int unsigned OUT_W    = 48;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic ins;   // shift right from the lower bound and drop in the new key
    logic take;  // shift every key one cell toward the head
    logic sgn;   // order keys as two's complement
  } skpq_ctl_t;

endpackage

FILE: hw/rtl/sorted_key_priority_queue_unit.sv
// Channel  Direction  tdata (low bit up)                                   tuser
// in_      slave      key[31:0], zero fill to 32                           operation[1:0]
// out_     master     accepted, key_out[31:0], found, count[7:0],          none
//                     is_empty, zero fill to 48
// cfg_     slave      signed_order[0]                                      none
//
// Every operation acts on a row of cells that holds the keys, one key per cell:
// each cell compares its key with the broadcast key and takes its own, its
// neighbor's or the new key at the same edge.
// A result is held in the output register; a new item is taken in the cycle
// that the held result leaves or once the register is empty.
// Reset (rst_n low, synchronous) empties the store and clears signed_order.
module sorted_key_priority_queue_unit #(
  parameter int unsigned DEPTH    = 128,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [skpq_pkg::IN_W-1:0]    in_tdata,   // key[31:0]
  input  logic [skpq_pkg::OP_W-1:0]    in_tuser,   // operation[1:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [skpq_pkg::OUT_W-1:0]   out_tdata,  // accepted, key_out, found, count, is_empty
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data    // signed_order
);
  import skpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                sgn_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic [OUT_W-1:0]    out_data_nxt;
  logic                in_fire;
  logic                full;
  logic                empty;
  logic [KEY_BITS-1:0] new_key;
  logic [1:0]          op;
  skpq_ctl_t           ctl;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    cell_ge;
  logic [DEPTH-1:0]    cell_match;
  logic [DEPTH-1:0]    cell_valid;

  logic                res_acc;
  logic [KEY_W-1:0]    res_key;
  logic                res_found;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign op      = in_tuser;
  assign new_key = KEY_BITS'(in_tdata);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);

  // Broadcast command to the cells.
  always_comb begin
    ctl.ins  = in_fire && (op == OP_INSERT) && !full;
    ctl.take = in_fire && (op == OP_TAKE) && !empty;
    ctl.sgn  = sgn_r;
  end

  // Row of cells, each handing its key and lower-bound flag to its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                prev_ge;
    logic [KEY_BITS-1:0] prev_key;
    logic [KEY_BITS-1:0] next_key;

    assign cell_valid[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_ge  = 1'b0;
      assign prev_key = '0;
    end else begin : g_body
      assign prev_ge  = cell_ge[i-1];
      assign prev_key = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key = '0;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    skpq_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .new_key (new_key),
      .valid   (cell_valid[i]),
      .prev_ge (prev_ge),
      .prev_key(prev_key),
      .next_key(next_key),
      .key     (cell_key[i]),
      .ge      (cell_ge[i]),
      .match   (cell_match[i])
    );
  end

  // Result fields and next count.
  always_comb begin
    res_acc   = 1'b0;
    res_key   = '0;
    res_found = 1'b0;
    count_nxt = count_r;
    unique case (op)
      OP_INSERT: begin
        res_acc = !full;
        if (!full) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_TAKE: begin
        res_acc = !empty;
        if (!empty) begin
          res_key   = KEY_W'(cell_key[0]);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        res_acc = !empty;
        if (!empty) begin
          res_key = KEY_W'(cell_key[0]);
        end
      end
      OP_TEST: begin
        res_acc   = 1'b1;
        res_found = |cell_match;
      end
      default: begin
        res_acc = 1'b0;
      end
    endcase
    out_data_nxt = OUT_W'({(count_nxt == '0), COUNT_W'(count_nxt), res_found, res_key, res_acc});
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sgn_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sgn_r <= cfg_data;
      end
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  // The count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count above capacity");

  // A successful take leaves one key fewer.
  a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("take did not lower the count");

  // A successful insert leaves one key more.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not raise the count");

  // The count only changes when an item is accepted.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("count changed without an item");
`endif

endmodule

FILE: hw/rtl/skpq_cell.sv
module skpq_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk,
  input  skpq_pkg::skpq_ctl_t ctl,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic                valid,
  input  logic                prev_ge,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic [KEY_BITS-1:0] next_key,
  output logic [KEY_BITS-1:0] key,
  output logic                ge,
  output logic                match
);
  import skpq_pkg::*;

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_nxt;
  logic [KEY_BITS-1:0] flip;
  logic [KEY_BITS-1:0] rank_own;
  logic [KEY_BITS-1:0] rank_new;

  // Flipping the sign bit maps two's complement order onto unsigned order.
  assign flip     = KEY_BITS'(ctl.sgn) << (KEY_BITS - 1);
  assign rank_own = key_r ^ flip;
  assign rank_new = new_key ^ flip;

  // An empty cell counts as larger than any key, so the flags stay monotone.
  assign ge    = !valid || (rank_own >= rank_new);
  assign match = valid && (key_r == new_key);
  assign key   = key_r;

  // Shift or load the held key.
  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      if (prev_ge) begin
        key_nxt = prev_key;
      end else if (ge) begin
        key_nxt = new_key;
      end
    end else if (ctl.take) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

FILE: sim/tb_sorted_key_priority_queue_unit.sv
`timescale 1ns / 100ps

module tb_sorted_key_priority_queue_unit;
  import skpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned FILL_CYCLES = 4;

  // Result fields, packed from the top bit down to bit 0.
  typedef struct packed {
    logic [4:0]         pad;
    logic               is_empty;
    logic [COUNT_W-1:0] count;
    logic               found;
    logic [KEY_W-1:0]   key_out;
    logic               accepted;
  } pq_result_t;

  // Mirror of the sorted store; works out the result of every accepted item.
  class pq_scoreboard;
    logic [KEY_W-1:0] keys [QUEUE_DEPTH];
    int unsigned      held;
    logic             signed_keys;
    pq_result_t       pending_results [$];
    int unsigned      failures;
    int unsigned      items_in;
    int unsigned      results_out;
    int unsigned      full_refusals;
    int unsigned      empty_refusals;
    int unsigned      member_hits;

    function new();
      held = 0;
      signed_keys = 1'b0;
      failures = 0;
      items_in = 0;
      results_out = 0;
      full_refusals = 0;
      empty_refusals = 0;
      member_hits = 0;
    endfunction

    // Flipping the sign bit turns a two's complement order into an unsigned one.
    function logic [KEY_W-1:0] rank(logic [KEY_W-1:0] k);
      return signed_keys ? (k ^ {1'b1, {(KEY_W-1){1'b0}}}) : k;
    endfunction

    // Binary search for the first stored key that is not below k.
    function int unsigned lower_bound(logic [KEY_W-1:0] k);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = held;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (rank(keys[mid]) < rank(k)) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    // Apply one accepted item to the store and queue the result it causes.
    function void apply_operation(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
      pq_result_t  r;
      int unsigned pos;
      r = '0;
      items_in++;
      case (op)
        OP_INSERT: begin
          if (held < QUEUE_DEPTH) begin
            pos = lower_bound(k);
            for (int unsigned i = held; i > pos; i--) keys[i] = keys[i-1];
            keys[pos] = k;
            held++;
            r.accepted = 1'b1;
          end else begin
            full_refusals++;
          end
        end
        OP_TAKE, OP_READ: begin
          if (held > 0) begin
            r.key_out = keys[0];
            r.accepted = 1'b1;
            if (op == OP_TAKE) begin
              for (int unsigned i = 1; i < held; i++) keys[i-1] = keys[i];
              held--;
            end
          end else begin
            empty_refusals++;
          end
        end
        OP_TEST: begin
          r.accepted = 1'b1;
          pos = lower_bound(k);
          if (pos < held && keys[pos] == k) begin
            r.found = 1'b1;
            member_hits++;
          end
        end
      endcase
      r.count = held[COUNT_W-1:0];
      r.is_empty = (held == 0);
      pending_results.push_back(r);
    endfunction

    function void report_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one result from the block with the oldest expected one.
    function void compare_result(logic [OUT_W-1:0] data);
      pq_result_t got;
      pq_result_t want;
      got = data;
      results_out++;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        return;
      end
      want = pending_results.pop_front();
      report_field("accepted", want.accepted, got.accepted);
      report_field("key_out", want.key_out, got.key_out);
      report_field("found", want.found, got.found);
      report_field("count", want.count, got.count);
      report_field("is_empty", want.is_empty, got.is_empty);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata = '0;
  logic [OP_W-1:0]    in_tuser = OP_INSERT;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  int unsigned        snd_idle = 34;
  int unsigned        rcv_idle = 83;
  int unsigned        stall_req = 0;
  int unsigned        stall_served = 0;
  int unsigned        stall_left = 0;

  pq_scoreboard       sb = new();

  logic [KEY_W-1:0]   edge_keys [8] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                                        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFE, 32'h8000_0001};

  sorted_key_priority_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_req != stall_served) begin
      stall_served <= stall_req;
      stall_left <= 300;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Every result that leaves the block is checked here.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.compare_result(out_tdata);
  end

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= k;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    sb.apply_operation(op, k);
  endtask

  // Wait until every expected result is out and the pipeline has settled.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (FILL_CYCLES) @(posedge clk);
  endtask

  // Empty the store first, so that the new order never meets keys sorted by the old one.
  task automatic set_order(logic sgn);
    while (sb.held > 0) send_item(OP_TAKE, $urandom);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= sgn;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.signed_keys = sgn;
  endtask

  // Keys lean toward the edges of the range and small values, so duplicates are common.
  function automatic logic [KEY_W-1:0] pick_key(bit for_test);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (for_test && sb.held > 0 && r < 50) return sb.keys[$urandom_range(0, sb.held - 1)];
    r = $urandom_range(0, 99);
    if (r < 20) return edge_keys[$urandom_range(0, 7)];
    if (r < 35) return $urandom_range(0, 15);
    return $urandom;
  endfunction

  // A run of random operations; the rest of the mix splits between read and member test.
  task automatic run_burst(int unsigned n, int unsigned ins_pct, int unsigned take_pct);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) send_item(OP_INSERT, pick_key(1'b0));
      else if (r < ins_pct + take_pct) send_item(OP_TAKE, $urandom);
      else if ($urandom_range(0, 2) == 0) send_item(OP_READ, $urandom);
      else send_item(OP_TEST, pick_key(1'b1));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extreme keys, a duplicate, then the signed order.
    set_order(1'b0);
    send_item(OP_TAKE, 32'h0);
    send_item(OP_READ, 32'h0);
    send_item(OP_TEST, 32'h0);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_READ, 32'hFFFF_FFFF);
    send_item(OP_TEST, 32'h8000_0000);
    send_item(OP_TEST, 32'h1234_5678);
    send_item(OP_TEST, 32'hFFFF_FFFF);
    repeat (6) send_item(OP_TAKE, 32'h0);
    set_order(1'b1);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_READ, 32'h0);
    send_item(OP_TEST, 32'h0000_0000);

    // Random: each phase fills the store past capacity, mixes, then drains it.
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle = (ph == 0) ? 34 : (ph == 1) ? 83 : 0;
      rcv_idle = (ph == 0) ? 83 : (ph == 1) ? 34 : 0;
      set_order(ph[0] ? 1'b0 : 1'b1);
      if (ph == 1) stall_req <= stall_req + 1;
      run_burst($urandom_range(140, 170), 92, 3);
      run_burst($urandom_range(20, 40), 35, 25);
      run_burst($urandom_range(120, 150), 3, 92);
    end
    wait_drained();

    if (sb.pending_results.size() != 0) sb.failures++;
    $display("Covered %0d items and %0d results in both key orders.",
             sb.items_in, sb.results_out);
    $display("Inserts refused when full: %0d, take/read on empty: %0d, member hits: %0d.",
             sb.full_refusals, sb.empty_refusals, sb.member_hits);
    if (sb.failures == 0) begin
      $display("[sorted_key_priority_queue_unit] OK");
    end else begin
      $display("[sorted_key_priority_queue_unit] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("[sorted_key_priority_queue_unit] ERROR");
    $finish;
  end

endmodule
